### rtl/engine_ignition_timing_controller_assert.svh
// Assertion macros for the ignition timing controller checker.
// Needs clk and rst_n in the scope where a macro is used.
`ifndef ENGINE_IGNITION_TIMING_CONTROLLER_ASSERT_SVH
`define ENGINE_IGNITION_TIMING_CONTROLLER_ASSERT_SVH

// Same-cycle implication, held off during reset.
`define EITC_ASSERT_IMP(name, pre, post) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
    else $error("eitc check failed");

// Next-cycle implication, held off during reset.
`define EITC_ASSERT_NXT(name, pre, post) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
    else $error("eitc check failed");

`endif

### rtl/eitc_pkg.sv
// Shared types and constants of the ignition timing controller.
// No dependencies; used by every module of the block.
package eitc_pkg;

  // Configuration port widths and register indexes.
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 26;

  localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_RPM_NUM  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_REV_LIM  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_CUT_TIME = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_MIN_INT  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_DWELL    = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_COIL     = 3'd6;

  // Register reset values.
  localparam logic [23:0] RST_TIMEOUT  = 24'd80000;
  localparam logic [25:0] RST_RPM_NUM  = 26'd15000000;
  localparam logic [15:0] RST_REV_LIM  = 16'd9000;
  localparam logic [23:0] RST_CUT_TIME = 24'd60000;
  localparam logic [15:0] RST_MIN_INT  = 16'd1000;
  localparam logic [15:0] RST_DWELL    = 16'd6000;
  localparam logic [6:0]  RST_COIL     = 7'd16;

  // Rpm divider geometry: the dividend is the rpm numerator, the divisor a
  // full pulse interval.
  localparam int DIVIDEND_W = 26;
  localparam int DIVISOR_W  = 24;
  localparam int DIV_CNT_W  = $clog2(DIVIDEND_W);
  localparam logic [DIV_CNT_W-1:0] DIV_LAST = DIV_CNT_W'(DIVIDEND_W - 1);

  // Spark delay: the interval times angle product is divided by 360 as a
  // shift by three followed by a multiply with ceil(2^34 / 45), which is
  // exact for every 28-bit value.
  localparam int PROD_W    = 31;
  localparam int DLY_SHIFT = 34;
  localparam logic [28:0] RECIP_45 = 29'd381774871;

  // Sequencer phase as seen on the result beat.
  typedef enum logic [2:0] {
    PH_IDLE  = 3'd0,
    PH_SHIFT = 3'd1,
    PH_CUT   = 3'd2,
    PH_FIRE  = 3'd3,
    PH_SAFE  = 3'd4
  } phase_t;

  // Controller states.
  typedef enum logic [2:0] {
    S_IDLE,
    S_PASS,
    S_RPM,
    S_BRANCH,
    S_MUL,
    S_DLY,
    S_WB
  } ctrl_state_t;

  // Payload of one input beat.
  typedef struct packed {
    logic trigger_level;
    logic cam_level;
    logic shifter_level;
  } in_item_t;

  // Payload of one result beat.
  typedef struct packed {
    logic        spark_out;
    logic [15:0] engine_speed;
    logic [3:0]  tooth_number;
    logic [2:0]  loop_phase;
  } out_item_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic ld_item;
    logic do_first;
    logic rpm_start;
    logic ld_speed;
    logic do_branch;
    logic ld_prod;
    logic ld_delay;
    logic do_wb;
  } ctrl_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic need_pass;
    logic first_cycle;
    logic need_delay;
    logic div_done;
    logic out_free;
  } dp_status_t;

endpackage

### rtl/eitc_div.sv
// Restoring divider, one quotient bit per cycle, used for the engine speed.
// Depends on eitc_pkg for the operand widths.
module eitc_div (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               start,
  input  logic [eitc_pkg::DIVIDEND_W-1:0]    dividend,
  input  logic [eitc_pkg::DIVISOR_W-1:0]     divisor,
  output logic                               done,
  output logic [eitc_pkg::DIVIDEND_W-1:0]    quotient
);

  logic                               busy_r, busy_nxt;
  logic                               done_r, done_nxt;
  logic [eitc_pkg::DIV_CNT_W-1:0]     cnt_r, cnt_nxt;
  logic [eitc_pkg::DIVISOR_W-1:0]     rem_r, rem_nxt;
  logic [eitc_pkg::DIVISOR_W-1:0]     dvs_r, dvs_nxt;
  logic [eitc_pkg::DIVIDEND_W-1:0]    quo_r, quo_nxt;
  logic [eitc_pkg::DIVISOR_W:0]       trial;
  logic [eitc_pkg::DIVISOR_W:0]       trial_diff;
  logic                               fits;

  // Shift the next dividend bit into the remainder and try a subtract.
  // A zero divisor always fits, which yields an all-ones quotient.
  always_comb begin
    trial      = {rem_r, quo_r[eitc_pkg::DIVIDEND_W-1]};
    trial_diff = trial - {1'b0, dvs_r};
    fits       = (trial >= {1'b0, dvs_r});
  end

  // Step control.
  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    rem_nxt  = rem_r;
    dvs_nxt  = dvs_r;
    quo_nxt  = quo_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = '0;
      rem_nxt  = '0;
      dvs_nxt  = divisor;
      quo_nxt  = dividend;
    end else if (busy_r) begin
      rem_nxt = fits ? trial_diff[eitc_pkg::DIVISOR_W-1:0] : trial[eitc_pkg::DIVISOR_W-1:0];
      quo_nxt = {quo_r[eitc_pkg::DIVIDEND_W-2:0], fits};
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == eitc_pkg::DIV_LAST) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  // Operand registers carry no reset.
  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    dvs_r <= dvs_nxt;
    quo_r <= quo_nxt;
  end

  assign done     = done_r;
  assign quotient = quo_r;

endmodule

### rtl/eitc_dp.sv
// Datapath: configuration, timing state, ignition sequencer state and the
// result register. Depends on eitc_pkg and instantiates eitc_div.
module eitc_dp #(
  parameter int ADVANCE_DEG = 16,
  parameter int TEETH       = 8
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  eitc_pkg::ctrl_cmd_t               cmd,
  output eitc_pkg::dp_status_t              status,
  input  eitc_pkg::in_item_t                in_data,
  input  logic                              cfg_we,
  input  logic [eitc_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [eitc_pkg::CFG_DATA_W-1:0]   cfg_data,
  output logic                              out_valid,
  input  logic                              out_ready,
  output eitc_pkg::out_item_t               out_data
);

  localparam logic [6:0] ADV        = ADVANCE_DEG[6:0];
  localparam logic [3:0] TOOTH_LAST = TEETH[3:0];
  localparam logic [3:0] TOOTH_PREV = TOOTH_LAST - 4'd1;

  // Configuration registers.
  logic [23:0] tmo_r, cut_r;
  logic [25:0] num_r;
  logic [15:0] rev_r, minint_r, dwell_r;
  logic [6:0]  coil_r;

  // Timing and sequencer state.
  logic [23:0]          tick_r, tick_nxt;
  logic [23:0]          pulse_r, pulse_nxt;
  logic [15:0]          speed_r, speed_nxt;
  logic [3:0]           tooth_r, tooth_nxt;
  logic                 first_r, first_nxt;
  logic                 spark_r, spark_nxt;
  eitc_pkg::phase_t     phase_r, phase_nxt;
  logic [23:0]          delay_r, delay_nxt;
  logic                 prev_r, prev_nxt;
  logic                 out_valid_r, out_valid_nxt;

  // Item and arithmetic holding registers.
  eitc_pkg::in_item_t   item_r;
  logic [eitc_pkg::PROD_W-1:0] prod_r;
  eitc_pkg::out_item_t  out_data_r, out_data_nxt;

  // Front end of a tick.
  logic        timeout;
  logic [23:0] tick_a;
  logic [3:0]  tooth_a;
  logic        trig_edge;

  // Sequencer decisions.
  logic        go_shift, go_cut, dwell, need_delay;
  logic [6:0]  ang_diff;
  logic [eitc_pkg::PROD_W-1:0] prod_w;

  // Spark delay from the registered product.
  logic [27:0] prod_eighth;
  logic [56:0] recip_prod;
  logic [23:0] delay_w;

  // Write-back view of the waits.
  eitc_pkg::phase_t wb_phase;
  logic             wb_spark;
  logic [24:0]      cut_target;

  // Divider hookup.
  logic                              div_start, div_done;
  logic [eitc_pkg::DIVIDEND_W-1:0]   div_dividend, div_quo;
  logic [eitc_pkg::DIVISOR_W-1:0]    div_divisor;

  assign div_start    = cmd.rpm_start;
  assign div_dividend = num_r;
  assign div_divisor  = pulse_r;

  eitc_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .done     (div_done),
    .quotient (div_quo)
  );

  // Counter advance with timeout, then trigger edge qualification.
  always_comb begin
    timeout   = (tick_r >= tmo_r);
    tick_a    = timeout ? 24'd0 : tick_r + 24'd1;
    tooth_a   = timeout ? 4'd0 : tooth_r;
    trig_edge = in_data.trigger_level && !prev_r && (tick_a > {8'd0, minint_r});
  end

  // Pass decisions; shifter and rev limit are checked before dwell.
  always_comb begin
    go_shift   = !item_r.shifter_level && spark_r;
    go_cut     = (speed_r >= rev_r) && spark_r;
    dwell      = ((tooth_r == TOOTH_PREV) && (speed_r > dwell_r)) || (tooth_r == TOOTH_LAST);
    need_delay = !go_shift && !go_cut && !item_r.cam_level;
    ang_diff   = (coil_r > ADV) ? coil_r - ADV : 7'd0;
    prod_w     = {7'd0, pulse_r} * {24'd0, ang_diff};
  end

  // Divide the product by 360: drop the factor eight by a shift, then
  // multiply by the reciprocal of 45. The quotient fits in 23 bits.
  always_comb begin
    prod_eighth = prod_r[eitc_pkg::PROD_W-1:3];
    recip_prod  = 57'(prod_eighth) * 57'(eitc_pkg::RECIP_45);
    delay_w     = {1'b0, recip_prod[56:eitc_pkg::DLY_SHIFT]};
  end

  // Waits, checked in the order fire, cut, shifter, safety.
  always_comb begin
    wb_phase   = phase_r;
    wb_spark   = spark_r;
    cut_target = {1'b0, delay_r} + {1'b0, cut_r};
    if (wb_phase == eitc_pkg::PH_FIRE && tick_r >= delay_r) begin
      wb_spark = 1'b1;
      wb_phase = eitc_pkg::PH_SAFE;
    end
    if (wb_phase == eitc_pkg::PH_CUT && {1'b0, tick_r} >= cut_target) begin
      wb_phase = eitc_pkg::PH_SAFE;
    end
    if (wb_phase == eitc_pkg::PH_SHIFT && item_r.shifter_level) begin
      wb_phase = eitc_pkg::PH_SAFE;
    end
    if (wb_phase == eitc_pkg::PH_SAFE && tick_r >= {8'd0, minint_r}) begin
      wb_phase = eitc_pkg::PH_IDLE;
    end
  end

  // Next state for each command.
  always_comb begin
    tick_nxt      = tick_r;
    pulse_nxt     = pulse_r;
    speed_nxt     = speed_r;
    tooth_nxt     = tooth_r;
    first_nxt     = first_r;
    spark_nxt     = spark_r;
    phase_nxt     = phase_r;
    delay_nxt     = delay_r;
    prev_nxt      = prev_r;
    out_data_nxt  = out_data_r;
    out_valid_nxt = out_valid_r && !out_ready;

    if (cmd.ld_item) begin
      tick_nxt  = tick_a;
      tooth_nxt = tooth_a;
      prev_nxt  = in_data.trigger_level;
      if (timeout) begin
        spark_nxt = 1'b1;
        first_nxt = 1'b1;
      end
      if (trig_edge) begin
        pulse_nxt = tick_a;
        tick_nxt  = 24'd0;
        if (tooth_a != 4'd0) begin
          tooth_nxt = (tooth_a >= TOOTH_LAST) ? 4'd1 : tooth_a + 4'd1;
        end
      end
    end

    // Not yet synchronized: wait for the cam reference.
    if (cmd.do_first) begin
      if (!item_r.cam_level) begin
        tooth_nxt = 4'd1;
        first_nxt = 1'b0;
      end
      phase_nxt = eitc_pkg::PH_SAFE;
    end

    // Speed saturates at full scale.
    if (cmd.ld_speed) begin
      speed_nxt = (div_quo[eitc_pkg::DIVIDEND_W-1:16] != '0) ? 16'hFFFF : div_quo[15:0];
    end

    if (cmd.do_branch) begin
      if (go_shift) begin
        phase_nxt = eitc_pkg::PH_SHIFT;
      end else if (go_cut) begin
        phase_nxt = eitc_pkg::PH_CUT;
      end else begin
        if (dwell) begin
          spark_nxt = 1'b0;
        end
        if (item_r.cam_level) begin
          phase_nxt = eitc_pkg::PH_SAFE;
        end
      end
    end

    if (cmd.ld_delay) begin
      delay_nxt = delay_w;
      phase_nxt = eitc_pkg::PH_FIRE;
    end

    // Close the tick and present its result beat.
    if (cmd.do_wb) begin
      phase_nxt     = wb_phase;
      spark_nxt     = wb_spark;
      out_valid_nxt = 1'b1;
      out_data_nxt  = '{spark_out:    wb_spark,
                        engine_speed: speed_r,
                        tooth_number: tooth_r,
                        loop_phase:   wb_phase};
    end
  end

  // Control and architectural state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tick_r      <= '0;
      pulse_r     <= '0;
      speed_r     <= '0;
      tooth_r     <= '0;
      first_r     <= 1'b1;
      spark_r     <= 1'b1;
      phase_r     <= eitc_pkg::PH_IDLE;
      delay_r     <= '0;
      prev_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      tick_r      <= tick_nxt;
      pulse_r     <= pulse_nxt;
      speed_r     <= speed_nxt;
      tooth_r     <= tooth_nxt;
      first_r     <= first_nxt;
      spark_r     <= spark_nxt;
      phase_r     <= phase_nxt;
      delay_r     <= delay_nxt;
      prev_r      <= prev_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Configuration registers; unknown indexes are dropped.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tmo_r    <= eitc_pkg::RST_TIMEOUT;
      num_r    <= eitc_pkg::RST_RPM_NUM;
      rev_r    <= eitc_pkg::RST_REV_LIM;
      cut_r    <= eitc_pkg::RST_CUT_TIME;
      minint_r <= eitc_pkg::RST_MIN_INT;
      dwell_r  <= eitc_pkg::RST_DWELL;
      coil_r   <= eitc_pkg::RST_COIL;
    end else if (cfg_we) begin
      unique case (cfg_index)
        eitc_pkg::CFG_TIMEOUT:  tmo_r    <= cfg_data[23:0];
        eitc_pkg::CFG_RPM_NUM:  num_r    <= cfg_data;
        eitc_pkg::CFG_REV_LIM:  rev_r    <= cfg_data[15:0];
        eitc_pkg::CFG_CUT_TIME: cut_r    <= cfg_data[23:0];
        eitc_pkg::CFG_MIN_INT:  minint_r <= cfg_data[15:0];
        eitc_pkg::CFG_DWELL:    dwell_r  <= cfg_data[15:0];
        eitc_pkg::CFG_COIL:     coil_r   <= cfg_data[6:0];
        default: ;
      endcase
    end
  end

  // Payload registers carry no reset.
  always_ff @(posedge clk) begin
    if (cmd.ld_item) begin
      item_r <= in_data;
    end
    if (cmd.ld_prod) begin
      prod_r <= prod_w;
    end
    out_data_r <= out_data_nxt;
  end

  assign status = '{need_pass:   (phase_r == eitc_pkg::PH_IDLE) && item_r.trigger_level,
                    first_cycle: first_r,
                    need_delay:  need_delay,
                    div_done:    div_done,
                    out_free:    !out_valid_r || out_ready};

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

### rtl/eitc_ctrl.sv
// Controller: sequences one tick through evaluation, the rpm divider, the
// spark delay and write-back. Depends on eitc_pkg for its state and command types.
module eitc_ctrl (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  eitc_pkg::dp_status_t  status,
  output eitc_pkg::ctrl_cmd_t   cmd
);

  eitc_pkg::ctrl_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= eitc_pkg::S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Next state and commands.
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    unique case (state_r)
      eitc_pkg::S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.ld_item = 1'b1;
          state_nxt   = eitc_pkg::S_PASS;
        end
      end
      eitc_pkg::S_PASS: begin
        if (!status.need_pass) begin
          state_nxt = eitc_pkg::S_WB;
        end else if (status.first_cycle) begin
          cmd.do_first = 1'b1;
          state_nxt    = eitc_pkg::S_WB;
        end else begin
          cmd.rpm_start = 1'b1;
          state_nxt     = eitc_pkg::S_RPM;
        end
      end
      eitc_pkg::S_RPM: begin
        if (status.div_done) begin
          cmd.ld_speed = 1'b1;
          state_nxt    = eitc_pkg::S_BRANCH;
        end
      end
      eitc_pkg::S_BRANCH: begin
        cmd.do_branch = 1'b1;
        state_nxt     = status.need_delay ? eitc_pkg::S_MUL : eitc_pkg::S_WB;
      end
      eitc_pkg::S_MUL: begin
        cmd.ld_prod = 1'b1;
        state_nxt   = eitc_pkg::S_DLY;
      end
      eitc_pkg::S_DLY: begin
        cmd.ld_delay = 1'b1;
        state_nxt    = eitc_pkg::S_WB;
      end
      eitc_pkg::S_WB: begin
        if (status.out_free) begin
          cmd.do_wb = 1'b1;
          state_nxt = eitc_pkg::S_IDLE;
        end
      end
      default: state_nxt = eitc_pkg::S_IDLE;
    endcase
  end

endmodule

### rtl/engine_ignition_timing_controller.sv
// Ignition timing controller, one timer tick per input beat and one result
// beat per tick. A plain tick is evaluated and written back before the next
// beat is accepted. A tick that starts an ignition pass while synchronized
// also runs the one-bit-per-cycle rpm divider; when the spark delay is
// computed, a product step and a reciprocal multiply by one 360th follow it.
// A finished result waits in the output register while the next beat is
// accepted; a result still stalled there at the next write-back holds that
// tick until the receiver takes it.
// Configuration writes are taken in every cycle.
module engine_ignition_timing_controller #(
  parameter int ADVANCE_DEG = 16,
  parameter int TEETH       = 8
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  eitc_pkg::in_item_t                in_data,
  output logic                              out_valid,
  input  logic                              out_ready,
  output eitc_pkg::out_item_t               out_data,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [eitc_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [eitc_pkg::CFG_DATA_W-1:0]   cfg_data
);

  eitc_pkg::ctrl_cmd_t  cmd;
  eitc_pkg::dp_status_t status;

  // Register writes are never stalled.
  assign cfg_ready = 1'b1;

  eitc_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .status   (status),
    .cmd      (cmd)
  );

  eitc_dp #(
    .ADVANCE_DEG (ADVANCE_DEG),
    .TEETH       (TEETH)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .status    (status),
    .in_data   (in_data),
    .cfg_we    (cfg_valid && cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

### rtl/eitc_checker.sv
// Port-level checks on the result channel of the ignition timing controller.
// Depends on eitc_pkg and the assertion macro header; bound to the top level.
`include "engine_ignition_timing_controller_assert.svh"

module eitc_checker #(
  parameter int TEETH = 8
) (
  input logic                 clk,
  input logic                 rst_n,
  input logic                 out_valid,
  input logic                 out_ready,
  input eitc_pkg::out_item_t  out_data
);

  // A stalled result beat keeps its value.
  `EITC_ASSERT_NXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_data))

  // Tooth and phase stay within their defined codes.
  `EITC_ASSERT_IMP(a_out_range, out_valid, (out_data.tooth_number <= TEETH[3:0]) && (out_data.loop_phase <= eitc_pkg::PH_SAFE))

  // Dwell only happens while the engine is synchronized.
  `EITC_ASSERT_IMP(a_dwell_synced, out_valid && !out_data.spark_out, out_data.tooth_number != 4'd0)

endmodule

bind engine_ignition_timing_controller eitc_checker #(.TEETH(TEETH)) u_eitc_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);
